[hw/rtl/alc_pkg.sv]
// Shared types, constants and codes of the list-with-cursor block.
`default_nettype none

package alc_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIRST  = 2'd1,
        OP_NEXT   = 2'd2,
        OP_REMOVE = 2'd3
    } alc_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_END   = 2'd2,
        ST_NOCUR = 2'd3
    } alc_status_t;

    typedef struct packed {
        alc_op_t                   opcode;
        logic signed [DATA_W-1:0]  data_in;
    } alc_req_t;

    typedef struct packed {
        alc_status_t               status;
        logic signed [DATA_W-1:0]  data_out;
        logic [COUNT_W-1:0]        entry_count;
    } alc_rsp_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic               wr_en;
        logic               shift_en;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   rd_idx;
        logic [DATA_W-1:0]  wr_data;
    } alc_cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/alc_cell.sv]
// One storage cell of the list: holds a single entry and takes its upper neighbour's on a shift.
`default_nettype none

module alc_cell
    import alc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [IDX_W-1:0]    cell_idx,
    input  wire alc_cell_ctrl_t      ctrl,
    input  wire logic [DATA_W-1:0]   upper_word,
    output logic [DATA_W-1:0]        word,
    output logic [DATA_W-1:0]        rd_word
);

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.wr_en && (cell_idx == ctrl.idx))
        begin
            word_next = ctrl.wr_data;
        end
        else if (ctrl.shift_en && (cell_idx >= ctrl.idx))
        begin
            // Cells at and above the removed place close the gap.
            word_next = upper_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (cell_idx == ctrl.rd_idx) ? word_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/alc_ctrl.sv]
// Controller: entry count, cursor, opcode decode and the registered result item.
`default_nettype none

module alc_ctrl
    import alc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire alc_req_t            req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output alc_rsp_t                 rsp,
    input  wire logic [DATA_W-1:0]   rd_word,
    output alc_cell_ctrl_t           cell_ctrl
);

    // The cursor is kept as position plus one, so zero means no current entry.
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] cur_reg;
    logic [COUNT_W-1:0] cur_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    alc_rsp_t           rsp_reg;
    alc_rsp_t           rsp_next;
    logic               accept;
    alc_status_t        status;
    logic [DATA_W-1:0]  dout;
    logic [COUNT_W-1:0] cur_dec;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign cur_dec   = cur_reg - COUNT_W'(1);

    always_comb
    begin
        count_next        = count_reg;
        cur_next          = cur_reg;
        status            = ST_OK;
        dout              = '0;
        cell_ctrl.wr_en    = 1'b0;
        cell_ctrl.shift_en = 1'b0;
        cell_ctrl.idx      = count_reg[IDX_W-1:0];
        cell_ctrl.rd_idx   = cur_reg[IDX_W-1:0];
        cell_ctrl.wr_data  = req.data_in;
        unique case (req.opcode)
            OP_INSERT:
            begin
                if (count_reg == COUNT_W'(CAPACITY))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cell_ctrl.wr_en = accept;
                    count_next      = count_reg + COUNT_W'(1);
                end
            end
            OP_FIRST:
            begin
                cell_ctrl.rd_idx = '0;
                if (count_reg == '0)
                begin
                    status = ST_END;
                end
                else
                begin
                    cur_next = COUNT_W'(1);
                    dout     = rd_word;
                end
            end
            OP_NEXT:
            begin
                // The entry after the cursor sits at the stored position-plus-one value.
                if (cur_reg >= count_reg)
                begin
                    status = ST_END;
                end
                else
                begin
                    cur_next = cur_reg + COUNT_W'(1);
                    dout     = rd_word;
                end
            end
            OP_REMOVE:
            begin
                cell_ctrl.rd_idx = cur_dec[IDX_W-1:0];
                cell_ctrl.idx    = cur_dec[IDX_W-1:0];
                if ((cur_reg == '0) || (cur_reg > count_reg))
                begin
                    status = ST_NOCUR;
                end
                else
                begin
                    cell_ctrl.shift_en = accept;
                    dout               = rd_word;
                    count_next         = count_reg - COUNT_W'(1);
                    cur_next           = cur_dec;
                end
            end
            default:
            begin
                status = ST_NOCUR;
            end
        endcase

        rsp_next.status      = status;
        rsp_next.data_out    = dout;
        rsp_next.entry_count = count_next;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
                cur_reg   <= cur_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[hw/rtl/array_list_with_cursor.sv]
// The result item is registered and appears in the cycle after its request item is accepted.
// One item per cycle is taken; every cell shifts at once, and the single result
// register is the only stage, so a request waits only while a result is stalled.
// Reset clears the entry count, the cursor (no current entry) and the result valid;
// the entries themselves are undefined until written and need no clearing pass.
`default_nettype none

module array_list_with_cursor
    import alc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire alc_req_t  req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output alc_rsp_t       rsp
);

    alc_cell_ctrl_t    cell_ctrl;
    logic [DATA_W-1:0] cell_word [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];
    logic [DATA_W-1:0] rd_word;

    alc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .rd_word   (rd_word),
        .cell_ctrl (cell_ctrl)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] upper;

        // The top cell has no neighbour; what it takes on a shift lies beyond the count.
        if (i == CAPACITY - 1)
        begin : g_top
            assign upper = cell_word[i];
        end
        else
        begin : g_mid
            assign upper = cell_word[i + 1];
        end

        alc_cell u_cell (
            .clk        (clk),
            .cell_idx   (IDX_W'(i)),
            .ctrl       (cell_ctrl),
            .upper_word (upper),
            .word       (cell_word[i]),
            .rd_word    (cell_rd[i])
        );
    end

    // Only the addressed cell drives a non-zero read word, so the read bus is an OR.
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("accepted item produced no result");

    a_stall_only_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled while result register was free");

    a_full_at_capacity : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_FULL)) |-> (rsp.entry_count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    a_failed_data_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.data_out == '0))
        else $error("failed operation returned non-zero data");

endmodule

`default_nettype wire

[tb/sv/array_list_with_cursor_test.sv]
// Self-checking testbench for the ordered list with a read cursor.
module array_list_with_cursor_test;
    import alc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int SETTLE_CYCLES = 8;
    localparam longint TIMEOUT_NS = 10_000_000;

    typedef struct {
        alc_req_t req;
        int       gap;
    } pending_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    alc_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    alc_rsp_t rsp;

    // Items still to be driven, and results the list should still return.
    pending_t feed[$];
    alc_rsp_t awaited[$];

    // Shadow copy of the list contents, count and cursor.
    logic [DATA_W-1:0] shadow_words[CAPACITY];
    int shadow_count = 0;
    int shadow_cursor = -1;

    pending_t staged;
    logic     have_staged = 1'b0;
    logic     req_took = 1'b0;
    int       stall_left = 0;
    int       results_seen = 0;
    int       fault_count = 0;
    int       op_seen[4] = '{default: 0};
    int       status_seen[4] = '{default: 0};

    array_list_with_cursor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly no idling, sometimes a short pause, now and then a long one.
    function automatic int idle_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic alc_op_t random_op();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return OP_INSERT;
        else if (r == 4)
            return OP_FIRST;
        else if (r < 8)
            return OP_NEXT;
        return OP_REMOVE;
    endfunction

    function automatic void add_item(alc_op_t op, logic [DATA_W-1:0] word);
        pending_t p;
        p.req.opcode = op;
        p.req.data_in = word;
        // Every third stretch of eighty items is driven back to back.
        p.gap = idle_len((feed.size() / 80) % 3 == 1);
        feed.push_back(p);
    endfunction

    // Applies one operation to the shadow list and returns the result it gives.
    function automatic alc_rsp_t list_apply(alc_req_t r);
        alc_rsp_t res;
        int i;
        res.status = ST_OK;
        res.data_out = '0;
        case (r.opcode)
            OP_INSERT:
                if (shadow_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_count] = r.data_in;
                    shadow_count++;
                end
            OP_FIRST:
                if (shadow_count == 0)
                    res.status = ST_END;
                else
                begin
                    shadow_cursor = 0;
                    res.data_out = shadow_words[0];
                end
            OP_NEXT:
                if (shadow_cursor >= shadow_count - 1)
                    res.status = ST_END;
                else
                begin
                    shadow_cursor++;
                    res.data_out = shadow_words[shadow_cursor];
                end
            OP_REMOVE:
                if (shadow_cursor < 0 || shadow_cursor >= shadow_count)
                    res.status = ST_NOCUR;
                else
                begin
                    res.data_out = shadow_words[shadow_cursor];
                    for (i = shadow_cursor; i < shadow_count - 1; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                    shadow_cursor--;
                end
        endcase
        res.entry_count = COUNT_W'(shadow_count);
        return res;
    endfunction

    // Request driver: a new item goes out only once the previous one was taken.
    always @(negedge clk)
    begin
        logic drive_valid;
        if (rst_n && (!req_valid || req_took))
        begin
            drive_valid = 1'b0;
            if (!have_staged && feed.size() != 0)
            begin
                staged = feed.pop_front();
                have_staged = 1'b1;
            end
            if (have_staged && staged.gap == 0)
            begin
                req <= staged.req;
                drive_valid = 1'b1;
                have_staged = 1'b0;
            end
            else if (have_staged)
                staged.gap--;
            req_valid <= drive_valid;
        end
    end

    // Result stall: every third stretch of ninety results sees no back-pressure.
    always @(negedge clk)
    begin
        if (stall_left == 0)
            stall_left = idle_len((results_seen / 90) % 3 == 2);
        rsp_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    // Monitor: checks each returned item, then records any request taken this edge.
    always @(posedge clk)
    begin
        alc_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (awaited.size() == 0)
                begin
                    $error("result item with no request outstanding");
                    fault_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fault_count++;
                    end
                    if (rsp.data_out !== want.data_out)
                    begin
                        $error("data_out: expected %08h, got %08h",
                               want.data_out, rsp.data_out);
                        fault_count++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp.entry_count);
                        fault_count++;
                    end
                end
            end
            req_took = req_valid && !req_stall;
            if (req_took)
            begin
                want = list_apply(req);
                awaited.push_back(want);
                op_seen[req.opcode]++;
                status_seen[want.status]++;
            end
        end
    end

    initial
    begin
        int burst;
        // Empty list: nothing to read and nothing to remove.
        add_item(OP_FIRST, 32'h1234_5678);
        add_item(OP_NEXT, 32'hFFFF_FFFF);
        add_item(OP_REMOVE, 32'h0);
        add_item(OP_INSERT, 32'h7FFF_FFFF);
        add_item(OP_INSERT, 32'h8000_0000);
        add_item(OP_INSERT, 32'h0000_0000);
        add_item(OP_INSERT, 32'hFFFF_FFFF);
        add_item(OP_INSERT, 32'hAAAA_AAAA);
        add_item(OP_INSERT, 32'h5555_5555);
        // No current entry yet, so removal is refused and next starts at the head.
        add_item(OP_REMOVE, 32'h0);
        add_item(OP_NEXT, 32'h0);
        add_item(OP_NEXT, 32'h0);
        add_item(OP_REMOVE, 32'h0);
        add_item(OP_NEXT, 32'h0);
        add_item(OP_FIRST, 32'h0);
        // Removing the head leaves no current entry.
        add_item(OP_REMOVE, 32'h0);
        add_item(OP_REMOVE, 32'h0);
        repeat (5)
            add_item(OP_NEXT, 32'h0);
        add_item(OP_REMOVE, 32'h0);
        add_item(OP_NEXT, 32'h0);
        add_item(OP_INSERT, 32'hDEAD_BEEF);
        add_item(OP_NEXT, 32'h0);

        burst = feed.size() + RANDOM_ITEMS;
        while (feed.size() < burst)
        begin
            case ($urandom_range(0, 19))
                0:
                    // Fill past capacity so that inserts are refused.
                    repeat ($urandom_range(CAPACITY + 2, CAPACITY + 8))
                        add_item(OP_INSERT, random_word());
                1:
                begin
                    // Walk the list removing entries, often down to empty.
                    add_item(OP_FIRST, random_word());
                    repeat ($urandom_range(8, CAPACITY + 4))
                    begin
                        add_item(OP_REMOVE, random_word());
                        add_item(OP_NEXT, random_word());
                    end
                end
                default:
                    repeat ($urandom_range(1, 8))
                        add_item(random_op(), random_word());
            endcase
        end

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (feed.size() != 0 || have_staged || req_valid || awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Requests: %0d inserts, %0d firsts, %0d nexts, %0d removes.",
                 op_seen[OP_INSERT], op_seen[OP_FIRST], op_seen[OP_NEXT],
                 op_seen[OP_REMOVE]);
        $display("Results: %0d ok, %0d full, %0d end, %0d no-current; %0d checked.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_END],
                 status_seen[ST_NOCUR], results_seen);
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding.", awaited.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
hw/rtl/alc_pkg.sv
hw/rtl/alc_cell.sv
hw/rtl/alc_ctrl.sv
hw/rtl/array_list_with_cursor.sv
tb/sv/array_list_with_cursor_test.sv
